[sv/erg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erg_pkg: shared types and constants of the envelope ratio gain balancer
// Fixed-point limits, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package erg_pkg;

    // integrator pole and rounding, Q0.24
    localparam logic [24:0] Q24One         = 25'h100_0000;
    localparam logic [23:0] SmoothingReset = 24'd16755269;
    localparam logic [41:0] RoundHalf      = 42'h000_0080_0000;

    // gain limits, Q4.16
    localparam logic [19:0] GainMin = 20'd6554;
    localparam logic [19:0] GainMax = 20'd655360;

    // largest envelope value, Q1.16 magnitude 1.0
    localparam logic [16:0] EnvMax = 17'h1_0000;

    // sequencer step counts
    localparam int unsigned MacSteps = 4;
    localparam int unsigned DivSteps = 20;
    localparam int unsigned CntW     = $clog2(DivSteps);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV_INIT,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } erg_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mac;
        logic mac_first;
        logic mac_chan;
        logic div_init;
        logic div_step;
        logic mul;
        logic out_load;
    } erg_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_bypass;
    } erg_status_t;

endpackage

[sv/erg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erg_ctrl: sequencer of the envelope ratio gain balancer
// Steps the datapath through envelope update, division, gain multiply and
// output load, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module erg_ctrl
    import erg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  erg_status_t status,
    output erg_cmd_t    cmd
);

    erg_state_t        state_reg, state_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;

    // state, counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.mac       = 1'b1;
                cmd.mac_first = ~cnt_reg[0];
                cmd.mac_chan  = cnt_reg[1];
                if (cnt_reg == CntW'(MacSteps - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DIV_INIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = status.div_bypass ? ST_MUL : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CntW'(DivSteps - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_load_starts_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_MAC) && (cnt_reg == '0))
        else $error("accepted word did not start the envelope update");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.mac, cmd.div_init, cmd.div_step, cmd.mul,
                  cmd.out_load}))
        else $error("more than one datapath command in a cycle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("pending output word overwritten");
`endif

endmodule

[sv/erg_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erg_dp: datapath of the envelope ratio gain balancer
// Shared multiply-accumulate for both envelopes, radix-2 restoring divider
// for the gain, gain clamp and multiply, and the output register.
// ----------------------------------------------------------------------------
module erg_dp
    import erg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  erg_cmd_t           cmd,
    output erg_status_t        status,
    input  logic               cfg_we,
    input  logic [23:0]        cfg_data,
    input  logic signed [15:0] in_signal_sample,
    input  logic signed [15:0] in_compare_sample,
    input  logic               in_block_last,
    output logic signed [15:0] out_balanced_sample,
    output logic [19:0]        out_gain,
    output logic               out_result_last
);

    logic [23:0]        smoothing_reg;
    logic [16:0]        sig_env_reg, sig_env_next;
    logic [16:0]        cmp_env_reg, cmp_env_next;
    logic signed [15:0] sig_s_reg;
    logic signed [15:0] cmp_s_reg;
    logic               last_reg;
    logic [41:0]        acc_reg;
    logic [16:0]        rem_reg;
    logic [19:0]        dvd_reg;
    logic [19:0]        quo_reg;
    logic [19:0]        gain_reg;
    logic signed [36:0] prod_reg;
    logic signed [15:0] bal_reg;
    logic [19:0]        gain_out_reg;
    logic               last_out_reg;

    logic signed [15:0] mac_sample;
    logic [15:0]        mac_abs;
    logic [16:0]        mac_mag;
    logic [16:0]        mac_env;
    logic [16:0]        op_a;
    logic [24:0]        op_b;
    logic [41:0]        mac_prod;
    logic [41:0]        mac_sum;
    logic               sig_zero;
    logic               gain_high;
    logic [17:0]        div_trial;
    logic               div_ge;
    logic [19:0]        gain_clamped;
    logic signed [36:0] round_sum;
    logic signed [20:0] scaled;
    logic signed [15:0] bal_sat;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smoothing_reg <= SmoothingReset;
        end else if (cfg_we) begin
            smoothing_reg <= cfg_data;
        end
    end

    // multiply-accumulate operands: first term |x|*(1-a), second term env*a
    always_comb begin
        mac_sample = cmd.mac_chan ? cmp_s_reg : sig_s_reg;
        mac_env    = cmd.mac_chan ? cmp_env_reg : sig_env_reg;
        mac_abs    = mac_sample[15] ? 16'(-mac_sample) : 16'(mac_sample);
        mac_mag    = {mac_abs, 1'b0};
        op_a       = cmd.mac_first ? mac_mag : mac_env;
        op_b       = cmd.mac_first ? (Q24One - {1'b0, smoothing_reg})
                                   : {1'b0, smoothing_reg};
        mac_prod   = 42'(op_a) * 42'(op_b);
        mac_sum    = acc_reg + mac_prod;
    end

    // envelope write-back on the second term
    always_comb begin
        sig_env_next = sig_env_reg;
        cmp_env_next = cmp_env_reg;
        if (cmd.mac && !cmd.mac_first) begin
            if (cmd.mac_chan) begin
                cmp_env_next = mac_sum[40:24];
            end else begin
                sig_env_next = mac_sum[40:24];
            end
        end
    end

    // envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_env_reg <= '0;
            cmp_env_reg <= '0;
        end else begin
            sig_env_reg <= sig_env_next;
            cmp_env_reg <= cmp_env_next;
        end
    end

    // quotient overflow and zero divisor detection
    always_comb begin
        sig_zero          = (sig_env_reg == '0);
        gain_high         = ({4'b0, cmp_env_reg} >= {sig_env_reg, 4'b0});
        status.div_bypass = sig_zero || gain_high;
    end

    // one restoring division step
    always_comb begin
        div_trial = {rem_reg, dvd_reg[19]};
        div_ge    = (div_trial >= {1'b0, sig_env_reg});
    end

    // gain clamp to 0.1 .. 10
    always_comb begin
        priority if (quo_reg < GainMin) begin
            gain_clamped = GainMin;
        end else if (quo_reg > GainMax) begin
            gain_clamped = GainMax;
        end else begin
            gain_clamped = quo_reg;
        end
    end

    // output rounding and saturation
    always_comb begin
        round_sum = prod_reg + 37'sd32768;
        scaled    = 21'(round_sum >>> 16);
        priority if (scaled > 21'sd32767) begin
            bal_sat = 16'sh7fff;
        end else if (scaled < -21'sd32768) begin
            bal_sat = 16'sh8000;
        end else begin
            bal_sat = 16'(scaled);
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sig_s_reg <= in_signal_sample;
            cmp_s_reg <= in_compare_sample;
            last_reg  <= in_block_last;
        end
        if (cmd.mac && cmd.mac_first) begin
            acc_reg <= RoundHalf + mac_prod;
        end
        if (cmd.div_init) begin
            rem_reg <= {4'b0, cmp_env_reg[16:4]};
            dvd_reg <= {cmp_env_reg[3:0], 16'b0};
            if (sig_zero) begin
                quo_reg <= {3'b0, cmp_env_reg};
            end else if (gain_high) begin
                quo_reg <= GainMax;
            end else begin
                quo_reg <= '0;
            end
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? 17'(div_trial - {1'b0, sig_env_reg})
                              : 17'(div_trial);
            dvd_reg <= {dvd_reg[18:0], 1'b0};
            quo_reg <= {quo_reg[18:0], div_ge};
        end
        if (cmd.mul) begin
            gain_reg <= gain_clamped;
            prod_reg <= 37'(sig_s_reg) * $signed({17'b0, gain_clamped});
        end
        if (cmd.out_load) begin
            bal_reg      <= bal_sat;
            gain_out_reg <= gain_reg;
            last_out_reg <= last_reg;
        end
    end

    assign out_balanced_sample = bal_reg;
    assign out_gain            = gain_out_reg;
    assign out_result_last     = last_out_reg;

`ifndef SYNTHESIS
    a_env_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (sig_env_reg <= EnvMax) && (cmp_env_reg <= EnvMax))
        else $error("envelope above unity magnitude");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |=> (gain_reg >= GainMin) && (gain_reg <= GainMax))
        else $error("applied gain outside clamp range");
`endif

endmodule

[sv/envelope_ratio_gain_balancer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// envelope_ratio_gain_balancer: envelope-matched gain for a sample pair
// Tracks the envelopes of a signal and a comparison sample and scales the
// signal sample by their ratio, clamped to 0.1 .. 10.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | word
//  s_       | in        | s_valid / s_ready    | signal, compare sample, last
//  m_       | out       | m_valid / m_ready    | balanced sample, gain, last
//  cfg_     | in        | cfg_valid / cfg_ready| smoothing pole, Q0.24
//
// A word occupies the block from acceptance until its result is loaded into
// the output register: four steps on the shared envelope multiplier, then the
// 20-step radix-2 divider, skipped when the signal envelope is zero or the
// ratio reaches 16. Reset (synchronous, aresetn low) clears both envelopes
// and sets the pole to its default. A result waits in the output register
// while m_ready is low; the next word is taken once it is loaded there.
// ----------------------------------------------------------------------------
module envelope_ratio_gain_balancer
    import erg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_signal_sample,
    input  logic signed [15:0] s_compare_sample,
    input  logic               s_block_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_balanced_sample,
    output logic [19:0]        m_gain,
    output logic               m_result_last
);

    erg_cmd_t    cmd;
    erg_status_t status;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // sequencer
    erg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic
    erg_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .cfg_we              (cfg_valid & cfg_ready),
        .cfg_data            (cfg_data),
        .in_signal_sample    (s_signal_sample),
        .in_compare_sample   (s_compare_sample),
        .in_block_last       (s_block_last),
        .out_balanced_sample (m_balanced_sample),
        .out_gain            (m_gain),
        .out_result_last     (m_result_last)
    );

endmodule

[dv/envelope_ratio_gain_balancer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// envelope_ratio_gain_balancer_checker: result predictor and scoreboard
// Watches the config, input and result channels of the gain balancer. It keeps
// its own copy of the smoothing pole and both envelopes, predicts the
// balanced sample, gain and last flag of every accepted word, and compares
// each result word in order against the oldest prediction.
// ----------------------------------------------------------------------------
module envelope_ratio_gain_balancer_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [23:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_signal_sample,
    input  logic signed [15:0] s_compare_sample,
    input  logic               s_block_last,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_balanced_sample,
    input  logic [19:0]        m_gain,
    input  logic               m_result_last,
    output int                 mismatch_count,
    output int                 words_in_flight
);

    // fixed-point constants of the envelope and gain math
    localparam longint unsigned UnitQ24   = 64'd16777216;
    localparam longint unsigned RoundQ24  = 64'd8388608;
    localparam longint unsigned GainFloor = 64'd6554;
    localparam longint unsigned GainCeil  = 64'd655360;
    localparam logic [23:0]     ResetPole = 24'd16755269;

    typedef struct {
        logic signed [15:0] balanced;
        logic [19:0]        gain;
        logic               last;
    } balanced_word_t;

    balanced_word_t expected_words[$];
    logic [23:0]    pole         = ResetPole;
    logic [31:0]    signal_env   = '0;
    logic [31:0]    compare_env  = '0;
    int             fail_tally   = 0;

    initial begin
        mismatch_count  = 0;
        words_in_flight = 0;
    end

    // one-pole leaky integrator of |x|, x taken as Q16.16 magnitude
    function automatic logic [31:0] leak(input logic [31:0] env,
                                         input logic signed [15:0] x,
                                         input logic [23:0] a);
        longint          mag;
        longint unsigned acc;
        mag = x;
        if (mag < 0)
            mag = -mag;
        acc = longint'(mag << 1) * (UnitQ24 - 64'(a)) + 64'(a) * 64'(env) + RoundQ24;
        return acc[55:24];
    endfunction

    always @(posedge aclk) begin : monitor
        balanced_word_t  want;
        balanced_word_t  got;
        longint unsigned ratio;
        longint          product;
        longint          scaled;

        if (!aresetn) begin
            pole        = ResetPole;
            signal_env  = '0;
            compare_env = '0;
            expected_words.delete();
        end else begin
            // smoothing pole write
            if (cfg_valid && cfg_ready)
                pole = cfg_data;

            // predict the result of an accepted word
            if (s_valid && s_ready) begin
                signal_env  = leak(signal_env, s_signal_sample, pole);
                compare_env = leak(compare_env, s_compare_sample, pole);
                // a silent signal envelope passes the compare envelope as gain
                if (signal_env != 0)
                    ratio = (64'(compare_env) << 16) / 64'(signal_env);
                else
                    ratio = 64'(compare_env);
                if (ratio < GainFloor)
                    ratio = GainFloor;
                if (ratio > GainCeil)
                    ratio = GainCeil;
                product = longint'(s_signal_sample) * longint'(ratio) + 64'sd32768;
                scaled  = product >>> 16;
                if (scaled > 32767)
                    scaled = 32767;
                if (scaled < -32768)
                    scaled = -32768;
                want.balanced = 16'(scaled);
                want.gain     = 20'(ratio);
                want.last     = s_block_last;
                expected_words.push_back(want);
            end

            // compare a delivered result word with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no prediction pending: balanced_sample %0d gain %0d",
                           m_balanced_sample, m_gain);
                    fail_tally++;
                end else begin
                    got = expected_words.pop_front();
                    if (m_balanced_sample !== got.balanced) begin
                        $error("balanced_sample: expected %0d, actual %0d",
                               got.balanced, m_balanced_sample);
                        fail_tally++;
                    end
                    if (m_gain !== got.gain) begin
                        $error("gain: expected %0d, actual %0d", got.gain, m_gain);
                        fail_tally++;
                    end
                    if (m_result_last !== got.last) begin
                        $error("result_last: expected %0d, actual %0d",
                               got.last, m_result_last);
                        fail_tally++;
                    end
                end
            end
        end
        mismatch_count  <= fail_tally;
        words_in_flight <= expected_words.size();
    end

endmodule

[dv/envelope_ratio_gain_balancer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// envelope_ratio_gain_balancer_tb: top-level bench of the gain balancer
// Drives directed corner words and then random sample pairs under several
// smoothing poles and idle patterns, with a long output stall and a drain
// pause; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module envelope_ratio_gain_balancer_tb;

    localparam int unsigned CycleLimit    = 600000;
    localparam int unsigned HoldCycles    = 400;
    localparam int unsigned WordsPerPhase = 58;
    localparam int unsigned SettleCycles  = 40;
    localparam logic [23:0] DefaultPole   = 24'd16755269;
    localparam logic [23:0] SlowestPole   = 24'hFF_FFFF;
    localparam logic [23:0] FastestPole   = 24'h00_0000;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [23:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_signal_sample;
    logic signed [15:0] s_compare_sample;
    logic               s_block_last;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_balanced_sample;
    logic [19:0]        m_gain;
    logic               m_result_last;

    int mismatch_count;
    int words_in_flight;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_requests     = 0;
    int hold_served       = 0;
    int hold_left         = 0;
    int cycle_count       = 0;

    envelope_ratio_gain_balancer uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_signal_sample   (s_signal_sample),
        .s_compare_sample  (s_compare_sample),
        .s_block_last      (s_block_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_balanced_sample (m_balanced_sample),
        .m_gain            (m_gain),
        .m_result_last     (m_result_last)
    );

    envelope_ratio_gain_balancer_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_signal_sample   (s_signal_sample),
        .s_compare_sample  (s_compare_sample),
        .s_block_last      (s_block_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_balanced_sample (m_balanced_sample),
        .m_gain            (m_gain),
        .m_result_last     (m_result_last),
        .mismatch_count    (mismatch_count),
        .words_in_flight   (words_in_flight)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HoldCycles;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // mix of full-scale, quiet, silent, extreme and mid-level samples
    function automatic logic signed [15:0] pick_sample();
        int unsigned kind;
        int          level;
        kind = $urandom_range(0, 9);
        case (kind)
            4, 5: level = int'($urandom_range(0, 600)) - 300;
            6: level = 0;
            7: level = $urandom_range(0, 1) ? 32767 : -32768;
            8, 9: level = int'($urandom_range(0, 8192)) - 4096;
            default: level = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return 16'(level);
    endfunction

    // smoothing pole for each random phase
    function automatic logic [23:0] choose_pole(input int unsigned phase);
        case (phase % 6)
            0: return FastestPole;
            1: return SlowestPole;
            2: return DefaultPole;
            3: return 24'($urandom_range(0, 24'hFF_FFFF));
            4: return SlowestPole - 24'($urandom_range(0, 65535));
            default: return 24'($urandom_range(0, 1 << 20));
        endcase
    endfunction

    // offer one word, with random gaps before it
    task automatic offer_word(input logic signed [15:0] sig,
                              input logic signed [15:0] cmp,
                              input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_signal_sample  <= sig;
        s_compare_sample <= cmp;
        s_block_last     <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait for every predicted word to come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_in_flight != 0)
            @(posedge aclk);
    endtask

    task automatic write_pole(input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned regime;
        int unsigned phase;
        int unsigned word_idx;

        cfg_valid        <= 1'b0;
        cfg_data         <= '0;
        s_valid          <= 1'b0;
        s_signal_sample  <= '0;
        s_compare_sample <= '0;
        s_block_last     <= 1'b0;
        aresetn          <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // default pole: silent start, quiet signal against loud compare,
        // then full-scale jumps that saturate, most negative samples
        sender_idle_pct = 6;
        receiver_idle_pct <= 48;
        offer_word(16'sd0, 16'sd0, 1'b0);
        offer_word(16'sd0, 16'sd32767, 1'b1);
        offer_word(16'sd1, 16'sd32767, 1'b0);
        offer_word(16'sd32767, 16'sd32767, 1'b0);
        offer_word(-16'sd32768, -16'sd32768, 1'b1);
        offer_word(-16'sd1, -16'sd32768, 1'b0);
        offer_word(16'sd16384, -16'sd16384, 1'b1);
        offer_word(-16'sd21846, 16'sd21845, 1'b0);

        // no smoothing: envelopes follow the samples directly
        drain_results();
        write_pole(FastestPole);
        offer_word(16'sd1, 16'sd32767, 1'b0);
        offer_word(16'sd32767, 16'sd32767, 1'b1);
        offer_word(16'sd32767, 16'sd1, 1'b0);
        offer_word(16'sd0, 16'sd32767, 1'b1);
        offer_word(16'sd0, 16'sd1000, 1'b0);
        offer_word(-16'sd32768, -16'sd32768, 1'b1);
        offer_word(-16'sd32768, 16'sd0, 1'b0);

        // heaviest smoothing: envelopes hardly move
        drain_results();
        write_pole(SlowestPole);
        offer_word(16'sd12345, -16'sd12345, 1'b1);
        offer_word(-16'sd32768, 16'sd32767, 1'b0);
        offer_word(16'sd0, 16'sd0, 1'b1);

        // random words under three idle patterns and varied poles
        for (regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin
                    sender_idle_pct = 6;
                    receiver_idle_pct <= 48;
                end
                1: begin
                    sender_idle_pct = 48;
                    receiver_idle_pct <= 6;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct <= 0;
                end
            endcase
            for (phase = 0; phase < 4; phase++) begin
                drain_results();
                write_pole(choose_pole(regime * 4 + phase));
                // long output stall while input keeps coming
                if (regime == 2 && phase == 1)
                    hold_requests <= hold_requests + 1;
                for (word_idx = 0; word_idx < WordsPerPhase; word_idx++) begin
                    if (regime == 0 && phase == 2 && word_idx == 29)
                        drain_results();
                    offer_word(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
                end
            end
        end

        drain_results();
        repeat (SettleCycles) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
